// ----- rtl/core/wsf_pkg.sv -----
`timescale 1ns / 1ps
// shared types and constants of the weighted 3x3 smoothing filter
// no dependencies; imported by wsf_div10 and weighted_3x3_smoothing_filter
package wsf_pkg;

	// configuration register map
	typedef enum logic [0:0] {
		CFG_GRID_COLUMNS = 1'b0,
		CFG_GRID_ROWS    = 1'b1
	} cfg_reg_t;

	localparam int CFG_DATA_W      = 16;
	localparam int GRID_COLUMNS_W  = 11;
	localparam int GRID_ROWS_W     = 16;
	localparam int GRID_COLUMNS_RST = 64;
	localparam int GRID_ROWS_RST   = 64;

	// smallest grid edge that still has an interior
	localparam int MIN_DIM = 3;

	// sum of the kernel weights: eight neighbours plus the doubled centre
	localparam int DIVISOR = 10;

endpackage

// ----- rtl/core/wsf_div10.sv -----
`timescale 1ns / 1ps
// two-stage divide by the kernel weight sum: reciprocal multiply, then one correction step
// depends on wsf_pkg for the divisor
module wsf_div10 #(
	parameter int SAMPLE_BITS = 8
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [SAMPLE_BITS+3:0]      in_sum,
	input  logic                        in_last,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [SAMPLE_BITS-1:0]      out_quot,
	output logic                        out_last
);
	import wsf_pkg::*;

	localparam int SUM_W = SAMPLE_BITS + 4;
	localparam int SHIFT = SUM_W + 3;
	localparam int PROD_W = 2 * SUM_W;
	localparam int Q0_W = PROD_W - SHIFT;
	// floor of 2^SHIFT / divisor, so the first estimate is low by at most one
	localparam logic [SUM_W-1:0] RECIP = SUM_W'((64'd1 << SHIFT) / DIVISOR);

	logic                vld_s1;
	logic [PROD_W-1:0]   prod_s1;
	logic [SUM_W-1:0]    sum_s1;
	logic                last_s1;
	logic                vld_q;
	logic [SAMPLE_BITS-1:0] quot_q;
	logic                last_q;

	logic                out_free;
	logic                s1_free;
	logic [Q0_W-1:0]     q0;
	logic [SUM_W-1:0]    rem;
	logic [Q0_W-1:0]     q1;

	assign out_free = !vld_q || out_ready;
	assign s1_free  = !vld_s1 || out_free;
	assign in_ready = s1_free;

	assign q0  = prod_s1[PROD_W-1:SHIFT];
	assign rem = sum_s1 - SUM_W'(SUM_W'(q0) * SUM_W'(DIVISOR));
	assign q1  = q0 + Q0_W'(rem >= SUM_W'(DIVISOR));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_q  <= 1'b0;
		end else begin
			if (s1_free) begin
				vld_s1 <= in_valid;
			end
			if (out_free) begin
				vld_q <= vld_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_free && in_valid) begin
			prod_s1 <= PROD_W'(in_sum) * PROD_W'(RECIP);
			sum_s1  <= in_sum;
			last_s1 <= in_last;
		end
		if (out_free && vld_s1) begin
			quot_q <= q1[SAMPLE_BITS-1:0];
			last_q <= last_s1;
		end
	end

	assign out_valid = vld_q;
	assign out_quot  = quot_q;
	assign out_last  = last_q;

endmodule

// ----- rtl/core/weighted_3x3_smoothing_filter.sv -----
`timescale 1ns / 1ps
// weighted 3x3 smoothing filter: two line stores, sliding window, divide unit
// depends on wsf_pkg and wsf_div10
//
// channel  dir  payload                          handshake
// s_axis   in   tdata: sample                    tvalid / tready
// m_axis   out  tdata: smoothed, tlast: last_out tvalid / tready
// cfg      in   cfg_addr, cfg_wdata              cfg_wr_en, no wait
//
// one sample per clock sustained while m_axis takes results; a result passes line
// store read, window sum, multiply and correct once its lower-right neighbour is taken
// reset is immediate: line stores are not cleared, the counters keep every read
// that feeds a result on an entry written earlier in the same grid
// a stall on m_axis only backs up once every stage between the ports is full
module weighted_3x3_smoothing_filter #(
	parameter int MAX_COLUMNS = 1024,
	parameter int SAMPLE_BITS = 8
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     s_axis_tvalid,
	output logic                                     s_axis_tready,
	input  logic [((SAMPLE_BITS+7)/8)*8-1:0]         s_axis_tdata,  // sample
	output logic                                     m_axis_tvalid,
	input  logic                                     m_axis_tready,
	output logic [((SAMPLE_BITS+7)/8)*8-1:0]         m_axis_tdata,  // smoothed
	output logic                                     m_axis_tlast,
	input  logic                                     cfg_wr_en,
	input  wsf_pkg::cfg_reg_t                        cfg_addr,
	input  logic [wsf_pkg::CFG_DATA_W-1:0]           cfg_wdata
);
	import wsf_pkg::*;

	localparam int TDATA_W = ((SAMPLE_BITS + 7) / 8) * 8;
	localparam int COL_W   = $clog2(MAX_COLUMNS);
	localparam int SUM_W   = SAMPLE_BITS + 4;

	// configuration and position
	logic [GRID_COLUMNS_W-1:0] grid_columns_q;
	logic [GRID_ROWS_W-1:0]    grid_rows_q;
	logic [COL_W-1:0]          col_q;
	logic [GRID_ROWS_W-1:0]    row_q;
	logic [COL_W-1:0]          last_col;
	logic [GRID_ROWS_W-1:0]    last_row;
	logic [31:0]               cols_ext;

	// line stores
	logic [SAMPLE_BITS-1:0] line_a [MAX_COLUMNS];
	logic [SAMPLE_BITS-1:0] line_b [MAX_COLUMNS];

	// stage 1: line store data back
	logic                   vld_s1;
	logic [COL_W-1:0]       col_s1;
	logic [SAMPLE_BITS-1:0] sample_s1;
	logic [SAMPLE_BITS-1:0] top_s1;
	logic [SAMPLE_BITS-1:0] mid_s1;
	logic                   res_s1;
	logic                   last_s1;

	// stage 2: window sum
	logic                   vld_s2;
	logic [SUM_W-1:0]       sum_s2;
	logic                   last_s2;

	logic [SAMPLE_BITS-1:0] win_q [6];

	logic                   s_accept;
	logic                   s1_go;
	logic                   s2_free;
	logic                   div_ready;
	logic [SUM_W-1:0]       win_sum;
	logic [SAMPLE_BITS-1:0] quot;

	assign cols_ext = 32'(grid_columns_q);

	always_comb begin
		if (cols_ext < 32'(MIN_DIM)) begin
			last_col = COL_W'(MIN_DIM - 1);
		end else if (cols_ext > 32'(MAX_COLUMNS)) begin
			last_col = COL_W'(MAX_COLUMNS - 1);
		end else begin
			last_col = COL_W'(cols_ext - 32'd1);
		end
		if (grid_rows_q < GRID_ROWS_W'(MIN_DIM)) begin
			last_row = GRID_ROWS_W'(MIN_DIM - 1);
		end else begin
			last_row = grid_rows_q - GRID_ROWS_W'(1);
		end
	end

	// items with no result drop out after stage 1
	assign s2_free       = !vld_s2 || div_ready;
	assign s1_go         = vld_s1 && (!res_s1 || s2_free);
	assign s_axis_tready = !vld_s1 || s1_go;
	assign s_accept      = s_axis_tvalid && s_axis_tready;

	assign win_sum = SUM_W'(win_q[0]) + SUM_W'(win_q[1]) + SUM_W'(win_q[2])
		+ SUM_W'(win_q[3]) + (SUM_W'(win_q[4]) << 1) + SUM_W'(win_q[5])
		+ SUM_W'(top_s1) + SUM_W'(mid_s1) + SUM_W'(sample_s1);

	// configuration and position counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_columns_q <= GRID_COLUMNS_W'(GRID_COLUMNS_RST);
			grid_rows_q    <= GRID_ROWS_W'(GRID_ROWS_RST);
			col_q          <= '0;
			row_q          <= '0;
		end else if (cfg_wr_en) begin
			case (cfg_addr)
				CFG_GRID_COLUMNS: grid_columns_q <= cfg_wdata[GRID_COLUMNS_W-1:0];
				CFG_GRID_ROWS:    grid_rows_q    <= cfg_wdata[GRID_ROWS_W-1:0];
				default:          grid_columns_q <= grid_columns_q;
			endcase
			col_q <= '0;
			row_q <= '0;
		end else if (s_accept) begin
			if (col_q == last_col) begin
				col_q <= '0;
				row_q <= (row_q == last_row) ? '0 : row_q + GRID_ROWS_W'(1);
			end else begin
				col_q <= col_q + COL_W'(1);
			end
		end
	end

	// line stores: read on request, write back when the item leaves stage 1
	always_ff @(posedge clk) begin
		if (s_accept) begin
			top_s1 <= line_b[col_q];
			mid_s1 <= line_a[col_q];
		end
		if (s1_go) begin
			line_a[col_s1] <= sample_s1;
			line_b[col_s1] <= mid_s1;
		end
	end

	// pipeline control and window
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			for (int i = 0; i < 6; i++) begin
				win_q[i] <= '0;
			end
		end else begin
			if (s_axis_tready) begin
				vld_s1 <= s_axis_tvalid;
			end
			if (s2_free) begin
				vld_s2 <= s1_go && res_s1;
			end
			if (s1_go) begin
				win_q[0] <= win_q[3];
				win_q[1] <= win_q[4];
				win_q[2] <= win_q[5];
				win_q[3] <= top_s1;
				win_q[4] <= mid_s1;
				win_q[5] <= sample_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_accept) begin
			col_s1    <= col_q;
			sample_s1 <= s_axis_tdata[SAMPLE_BITS-1:0];
			res_s1    <= (row_q >= GRID_ROWS_W'(2)) && (col_q >= COL_W'(2));
			last_s1   <= (row_q == last_row) && (col_q == last_col);
		end
		if (s1_go && res_s1 && s2_free) begin
			sum_s2  <= win_sum;
			last_s2 <= last_s1;
		end
	end

	wsf_div10 #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (vld_s2),
		.in_ready  (div_ready),
		.in_sum    (sum_s2),
		.in_last   (last_s2),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_quot  (quot),
		.out_last  (m_axis_tlast)
	);

	assign m_axis_tdata = TDATA_W'(quot);

	// a new read never meets the write-back of the same column
	a_no_rw_collision: assert property (@(posedge clk) disable iff (!arst_n)
		(s_accept && s1_go) |-> (col_q != col_s1))
		else $error("line store read and write hit the same column");

	// a register write restarts the grid
	a_cfg_restart: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_wr_en |=> (col_q == '0 && row_q == '0))
		else $error("counters not cleared by register write");

	// an item held in stage 1 keeps its column
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s1 && !s1_go) |=> (vld_s1 && $stable(col_s1)))
		else $error("stage 1 item lost while stalled");

	// column counter stays inside the row
	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		(!$past(cfg_wr_en)) |-> (col_q <= last_col))
		else $error("column counter past the last column");

endmodule
